### rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int unsigned ArrW    = 16;
  localparam int unsigned BurstW  = 16;
  localparam int unsigned PriW    = 8;
  localparam int unsigned TimeW   = 21;
  localparam int unsigned JobIdxW = 4;
  localparam int unsigned InDataW  = 40;  // arrival, burst, priority
  localparam int unsigned OutDataW = 88;  // index, start, finish, turnaround, wait

  localparam logic EntryJob  = 1'b0;
  localparam logic EntryIdle = 1'b1;

  typedef struct packed {
    logic load;        // input beat accepted
    logic scan_start;  // restart the selection pass
    logic scan_run;    // step the selection pass
    logic commit;      // retire the pass into the output register
  } nps_cmd_t;

  typedef struct packed {
    logic scan_done;   // all stored jobs looked at
    logic out_free;    // output register can take a beat
    logic last_job;    // committing now ends the schedule
  } nps_status_t;

endpackage

### rtl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: loads jobs, then alternates selection passes and commits.
// ----------------------------------------------------------------------------
module nps_ctrl
  import nps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  input  nps_status_t status_i,
  output nps_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StLoad   = 3'b001,
    StScan   = 3'b010,
    StCommit = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.scan_start = 1'b1;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (status_i.last_job) begin
            state_d = StLoad;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = StScan;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/nps_datapath.sv
// ----------------------------------------------------------------------------
// nps_datapath
// Job memory, sequential selection pass, time keeping and output register.
// ----------------------------------------------------------------------------
module nps_datapath
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nps_cmd_t            cmd_i,
  output nps_status_t         status_o,
  input  logic [ArrW-1:0]     arrival_i,
  input  logic [BurstW-1:0]   burst_i,
  input  logic [PriW-1:0]     prio_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_type_o,
  output logic [JobIdxW-1:0]  out_index_o,
  output logic [TimeW-1:0]    out_start_o,
  output logic [TimeW-1:0]    out_finish_o,
  output logic [TimeW-1:0]    out_turn_o,
  output logic [TimeW-1:0]    out_wait_o,
  output logic                out_last_o
);

  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned IdxW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned WordW = ArrW + BurstW + PriW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_JOBS);

  logic [WordW-1:0] mem_q [MAX_JOBS];

  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     ptr_q, ptr_d;
  logic [CntW-1:0]     completed_q, completed_d;
  logic [TimeW-1:0]    cur_q, cur_d;
  logic [MAX_JOBS-1:0] done_q, done_d;

  logic [WordW-1:0] rd_q;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q;

  logic             best_vld_q, best_vld_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [ArrW-1:0]  best_arr_q, best_arr_d;
  logic [BurstW-1:0] best_bur_q, best_bur_d;
  logic [PriW-1:0]  best_pri_q, best_pri_d;
  logic [ArrW-1:0]  min_arr_q, min_arr_d;
  logic             min_vld_q, min_vld_d;

  logic             out_valid_q, out_valid_d;
  logic             out_type_q;
  logic [JobIdxW-1:0] out_index_q;
  logic [TimeW-1:0] out_start_q, out_finish_q, out_turn_q, out_wait_q;
  logic             out_last_q;

  logic [ArrW-1:0]   rd_arr;
  logic [BurstW-1:0] rd_bur;
  logic [PriW-1:0]   rd_pri;
  logic              cand_pend, cand_ready, cand_better;
  logic [TimeW-1:0]  fin_w, turn_w, wait_w;

  assign {rd_pri, rd_bur, rd_arr} = rd_q;

  // memory write on load, registered read during the pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < MaxCnt)) begin
      mem_q[count_q[IdxW-1:0]] <= {prio_i, burst_i, arrival_i};
    end
    rd_q     <= mem_q[ptr_q[IdxW-1:0]];
    rd_idx_q <= ptr_q[IdxW-1:0];
  end

  assign cand_pend   = rd_vld_q && !done_q[rd_idx_q];
  assign cand_ready  = cand_pend && (TimeW'(rd_arr) <= cur_q);
  assign cand_better = !best_vld_q || (rd_pri > best_pri_q) ||
                       ((rd_pri == best_pri_q) && (rd_arr < best_arr_q));

  // waiting is start minus arrival, so both subtract from registered values
  assign fin_w  = cur_q + TimeW'(best_bur_q);
  assign turn_w = fin_w - TimeW'(best_arr_q);
  assign wait_w = cur_q - TimeW'(best_arr_q);

  assign status_o.scan_done = (ptr_q == count_q) && !rd_vld_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.last_job  = best_vld_q && ((completed_q + CntW'(1)) == count_q);

  always_comb begin
    count_d     = count_q;
    ptr_d       = ptr_q;
    completed_d = completed_q;
    cur_d       = cur_q;
    done_d      = done_q;
    rd_vld_d    = 1'b0;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_arr_d  = best_arr_q;
    best_bur_d  = best_bur_q;
    best_pri_d  = best_pri_q;
    min_arr_d   = min_arr_q;
    min_vld_d   = min_vld_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load && (count_q < MaxCnt)) begin
      count_d = count_q + CntW'(1);
      done_d[count_q[IdxW-1:0]] = 1'b0;
    end

    if (cmd_i.scan_run) begin
      if (ptr_q < count_q) begin
        rd_vld_d = 1'b1;
        ptr_d    = ptr_q + CntW'(1);
      end
      if (cand_ready && cand_better) begin
        best_vld_d = 1'b1;
        best_idx_d = rd_idx_q;
        best_arr_d = rd_arr;
        best_bur_d = rd_bur;
        best_pri_d = rd_pri;
      end
      if (cand_pend && (!min_vld_q || (rd_arr < min_arr_q))) begin
        min_vld_d = 1'b1;
        min_arr_d = rd_arr;
      end
    end

    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
      if (best_vld_q) begin
        cur_d               = fin_w;
        done_d[best_idx_q]  = 1'b1;
        completed_d         = completed_q + CntW'(1);
        if (status_o.last_job) begin
          cur_d       = '0;
          completed_d = '0;
          count_d     = '0;
          done_d      = '0;
        end
      end else begin
        cur_d = TimeW'(min_arr_q);
      end
    end

    if (cmd_i.scan_start) begin
      ptr_d      = '0;
      best_vld_d = 1'b0;
      min_vld_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      completed_q <= '0;
      cur_q       <= '0;
      done_q      <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      min_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      completed_q <= completed_d;
      cur_q       <= cur_d;
      done_q      <= done_d;
      rd_vld_q    <= rd_vld_d;
      best_vld_q  <= best_vld_d;
      min_vld_q   <= min_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_arr_q <= best_arr_d;
    best_bur_q <= best_bur_d;
    best_pri_q <= best_pri_d;
    min_arr_q  <= min_arr_d;
    if (cmd_i.commit) begin
      out_start_q <= cur_q;
      if (best_vld_q) begin
        out_type_q   <= EntryJob;
        out_index_q  <= JobIdxW'(best_idx_q);
        out_finish_q <= fin_w;
        out_turn_q   <= turn_w;
        out_wait_q   <= wait_w;
        out_last_q   <= status_o.last_job;
      end else begin
        out_type_q   <= EntryIdle;
        out_index_q  <= '0;
        out_finish_q <= TimeW'(min_arr_q);
        out_turn_q   <= '0;
        out_wait_q   <= '0;
        out_last_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_type_o   = out_type_q;
  assign out_index_o  = out_index_q;
  assign out_start_o  = out_start_q;
  assign out_finish_o = out_finish_q;
  assign out_turn_o   = out_turn_q;
  assign out_wait_o   = out_wait_q;
  assign out_last_o   = out_last_q;

endmodule

### rtl/nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Loads a set of jobs and streams out their non-preemptive priority schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Jobs enter on the slave channel, one beat each, one per cycle while the
//   block is loading. The beat with tlast set closes the set; beats beyond
//   MAX_JOBS are dropped, though their tlast still closes the set.
//   The schedule then leaves on the master channel: one beat per run job or
//   idle interval, tuser set for idle, tlast on the final beat.
//   Each decision is a pass over the stored jobs through the single read
//   port of the job memory, followed by a commit that writes the result
//   beat into the output register. The first pass starts once the closing
//   input beat is accepted.
//   The slave side stays ready only while loading; the output register lets
//   the next pass run while a beat waits. When the receiver stalls, the
//   commit waits and the pass result is held.
//   Reset empties the job table, clears time and drops any pending beat.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // arrival_time, burst_length, job_priority
  input  logic                s_axis_tlast,   // end_of_set
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // job_index, start_time, finish_time,
                                              // turnaround, waiting
  output logic                m_axis_tuser,   // entry_type
  output logic                m_axis_tlast    // final_entry
);

  nps_cmd_t    cmd;
  nps_status_t status;

  logic [JobIdxW-1:0] out_index;
  logic [TimeW-1:0]   out_start, out_finish, out_turn, out_wait;

  nps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nps_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .arrival_i    (s_axis_tdata[15:0]),
    .burst_i      (s_axis_tdata[31:16]),
    .prio_i       (s_axis_tdata[39:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_type_o   (m_axis_tuser),
    .out_index_o  (out_index),
    .out_start_o  (out_start),
    .out_finish_o (out_finish),
    .out_turn_o   (out_turn),
    .out_wait_o   (out_wait),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_wait, out_turn, out_finish, out_start, out_index};

endmodule
